@@ rtl/core/ctfc_pkg.sv @@
// Shared types, register indexes and arithmetic helpers for the clock tree
// frequency calculator. No dependencies.
`default_nettype none

package ctfc_pkg;

  localparam int FreqW         = 32;
  localparam int DivW          = 6;
  localparam int StepsPerStage = 8;
  localparam int DivStages     = FreqW / StepsPerStage;
  localparam int CfgIdxW       = 3;
  localparam int MultW         = 9;
  localparam int ProdW         = FreqW + MultW;

  typedef logic [FreqW-1:0] freq_t;
  typedef logic [DivW-1:0]  div_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INT_OSC   = 3'd0,
    REG_EXT_OSC   = 3'd1,
    REG_MAX_CORE  = 3'd2,
    REG_MAX_APB_L = 3'd3,
    REG_MAX_APB_H = 3'd4,
    REG_MAX_AUDIO = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    freq_t      main_val;
    div_t       main_div;
    div_t       main_rem;
    freq_t      aud_val;
    div_t       aud_div;
    div_t       aud_rem;
    logic [8:0] main_n;
    logic [8:0] aud_n;
    logic [1:0] p_code;
    logic [2:0] aud_r;
    freq_t      sys_src;
    logic       pll_sel;
    logic       main_live;
    logic       aud_live;
    logic [3:0] ahb_code;
    logic [2:0] apb_low_code;
    logic [2:0] apb_high_code;
    logic [1:0] err;
  } item_t;

  typedef struct packed {
    freq_t core;
    freq_t apb_low;
    freq_t apb_high;
    freq_t audio;
  } lim_t;

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] s;
    unique case (code)
      4'd8:    s = 4'd1;
      4'd9:    s = 4'd2;
      4'd10:   s = 4'd3;
      4'd11:   s = 4'd4;
      4'd12:   s = 4'd6;
      4'd13:   s = 4'd7;
      4'd14:   s = 4'd8;
      4'd15:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] s;
    unique case (code)
      3'd4:    s = 3'd1;
      3'd5:    s = 3'd2;
      3'd6:    s = 3'd3;
      3'd7:    s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Eight restoring steps: shift dividend bits into the remainder, quotient
  // bits into the vacated low end. Returns {remainder, value}.
  function automatic logic [DivW+FreqW-1:0] div_chunk(input freq_t val, input div_t rem,
                                                      input div_t d);
    logic [DivW:0] t;
    freq_t         v;
    div_t          r;
    logic          ge;
    v = val;
    r = rem;
    for (int i = 0; i < StepsPerStage; i++) begin
      t  = {r, v[FreqW-1]};
      ge = (t >= {1'b0, d});
      v  = {v[FreqW-2:0], ge};
      r  = ge ? DivW'(t - {1'b0, d}) : t[DivW-1:0];
    end
    return {r, v};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ctfc_div.sv @@
// Pipelined dual-lane restoring divider, eight quotient bits per stage.
// Depends on ctfc_pkg.
`default_nettype none

module ctfc_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ctfc_pkg::item_t in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ctfc_pkg::item_t      out_item
);

  ctfc_pkg::item_t stg_r [ctfc_pkg::DivStages];
  logic            vld_r [ctfc_pkg::DivStages];
  logic            rdy   [ctfc_pkg::DivStages+1];

  assign rdy[ctfc_pkg::DivStages] = out_ready;

  for (genvar k = 0; k < ctfc_pkg::DivStages; k++) begin : g_stage
    ctfc_pkg::item_t src;
    logic            src_vld;
    ctfc_pkg::item_t stg_nxt;

    if (k == 0) begin : g_first
      assign src     = in_item;
      assign src_vld = in_valid;
    end else begin : g_rest
      assign src     = stg_r[k-1];
      assign src_vld = vld_r[k-1];
    end

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    always_comb begin
      stg_nxt = src;
      {stg_nxt.main_rem, stg_nxt.main_val} =
        ctfc_pkg::div_chunk(src.main_val, src.main_rem, src.main_div);
      {stg_nxt.aud_rem, stg_nxt.aud_val} =
        ctfc_pkg::div_chunk(src.aud_val, src.aud_rem, src.aud_div);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld;
      end
      if (rdy[k] && src_vld) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[ctfc_pkg::DivStages-1];
  assign out_item  = stg_r[ctfc_pkg::DivStages-1];

endmodule

`default_nettype wire

@@ rtl/core/ctfc_mul.sv @@
// VCO multiply stage: quotient times N for both PLLs, wrap flag, and setup
// of the output divisors. Depends on ctfc_pkg.
`default_nettype none

module ctfc_mul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ctfc_pkg::item_t in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ctfc_pkg::item_t      out_item
);

  logic                           vld_r;
  ctfc_pkg::item_t                item_r;
  ctfc_pkg::item_t                item_nxt;
  logic [ctfc_pkg::ProdW-1:0]     main_prod;
  logic [ctfc_pkg::ProdW-1:0]     aud_prod;
  logic [2:0]                     p_half;

  assign main_prod = ctfc_pkg::ProdW'(in_item.main_val) * ctfc_pkg::ProdW'(in_item.main_n);
  assign aud_prod  = ctfc_pkg::ProdW'(in_item.aud_val) * ctfc_pkg::ProdW'(in_item.aud_n);
  assign p_half    = 3'(in_item.p_code) + 3'd1;

  always_comb begin
    item_nxt          = in_item;
    item_nxt.main_val = in_item.main_live ? main_prod[ctfc_pkg::FreqW-1:0] : '0;
    item_nxt.aud_val  = in_item.aud_live ? aud_prod[ctfc_pkg::FreqW-1:0] : '0;
    item_nxt.main_div = ctfc_pkg::DivW'({p_half, 1'b0});
    item_nxt.aud_div  = ctfc_pkg::DivW'(in_item.aud_r);
    item_nxt.main_rem = '0;
    item_nxt.aud_rem  = '0;
    item_nxt.err[1]   = in_item.err[1]
                      | (in_item.main_live && (|main_prod[ctfc_pkg::ProdW-1:ctfc_pkg::FreqW]))
                      | (in_item.aud_live && (|aud_prod[ctfc_pkg::ProdW-1:ctfc_pkg::FreqW]));
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

@@ rtl/core/ctfc_bus.sv @@
// Bus clock stage: system clock select, prescaler shifts, limit compares and
// the output register. Depends on ctfc_pkg.
`default_nettype none

module ctfc_bus (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ctfc_pkg::lim_t  lim,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ctfc_pkg::item_t in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ctfc_pkg::freq_t      out_sysclk_hz,
  output ctfc_pkg::freq_t      out_core_hz,
  output ctfc_pkg::freq_t      out_apb_low_hz,
  output ctfc_pkg::freq_t      out_apb_high_hz,
  output ctfc_pkg::freq_t      out_audio_hz,
  output logic [3:0]           out_over_limit,
  output logic [1:0]           out_math_error
);

  logic            a_vld_r, a_rdy;
  ctfc_pkg::freq_t a_sys_r, a_core_r, a_p1_r, a_p2_r, a_aud_r;
  logic [1:0]      a_err_r;
  ctfc_pkg::freq_t sys_nxt, core_nxt;

  logic            b_vld_r;
  ctfc_pkg::freq_t b_sys_r, b_core_r, b_p1_r, b_p2_r, b_aud_r;
  logic [3:0]      b_lim_r;
  logic [1:0]      b_err_r;

  assign sys_nxt  = in_item.pll_sel ? in_item.main_val : in_item.sys_src;
  assign core_nxt = sys_nxt >> ctfc_pkg::ahb_shift(in_item.ahb_code);

  assign a_rdy    = !b_vld_r || out_ready;
  assign in_ready = !a_vld_r || a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_ready) begin
      a_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_sys_r  <= sys_nxt;
      a_core_r <= core_nxt;
      a_p1_r   <= core_nxt >> ctfc_pkg::apb_shift(in_item.apb_low_code);
      a_p2_r   <= core_nxt >> ctfc_pkg::apb_shift(in_item.apb_high_code);
      a_aud_r  <= in_item.aud_live ? in_item.aud_val : '0;
      a_err_r  <= in_item.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (a_rdy) begin
      b_vld_r <= a_vld_r;
    end
    if (a_rdy && a_vld_r) begin
      b_sys_r  <= a_sys_r;
      b_core_r <= a_core_r;
      b_p1_r   <= a_p1_r;
      b_p2_r   <= a_p2_r;
      b_aud_r  <= a_aud_r;
      b_err_r  <= a_err_r;
      b_lim_r  <= {a_aud_r > lim.audio, a_p2_r > lim.apb_high,
                   a_p1_r > lim.apb_low, a_core_r > lim.core};
    end
  end

  assign out_valid       = b_vld_r;
  assign out_sysclk_hz   = b_sys_r;
  assign out_core_hz     = b_core_r;
  assign out_apb_low_hz  = b_p1_r;
  assign out_apb_high_hz = b_p2_r;
  assign out_audio_hz    = b_aud_r;
  assign out_over_limit  = b_lim_r;
  assign out_math_error  = b_err_r;

  // Prescalers only divide down.
  a_core_le_sys: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> b_core_r <= b_sys_r) else $error("core above sysclk");
  a_p1_le_core: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> b_p1_r <= b_core_r) else $error("APB1 above core");
  a_p2_le_core: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> b_p2_r <= b_core_r) else $error("APB2 above core");

endmodule

`default_nettype wire

@@ rtl/core/clock_tree_frequency_calc.sv @@
// Clock tree frequency calculator: a request passes the capture register, the
// M divider, VCO multiply, P/R divider and bus stages, in that order.
// Throughput one request per cycle if not stalled; every stage is elastic, so a
// stalled result holds only its own stage while bubbles ahead of it still fill.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults; payload registers are not reset. Depends on ctfc_pkg and submodules.
`default_nettype none

module clock_tree_frequency_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_switch_status,
  input  wire logic        in_pll_from_external,
  input  wire logic [5:0]  in_main_div_m,
  input  wire logic [8:0]  in_main_mult_n,
  input  wire logic [1:0]  in_main_p_code,
  input  wire logic [3:0]  in_ahb_code,
  input  wire logic [2:0]  in_apb_low_code,
  input  wire logic [2:0]  in_apb_high_code,
  input  wire logic [5:0]  in_audio_div_m,
  input  wire logic [8:0]  in_audio_mult_n,
  input  wire logic [2:0]  in_audio_div_r,
  input  wire logic        in_audio_ready,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sysclk_hz,
  output logic [31:0]      out_core_hz,
  output logic [31:0]      out_apb_low_hz,
  output logic [31:0]      out_apb_high_hz,
  output logic [31:0]      out_audio_hz,
  output logic [3:0]       out_over_limit,
  output logic [1:0]       out_math_error
);

  // Configuration registers. Write them only while the pipe is idle: the
  // capture and bus stages read them for requests already in flight.
  ctfc_pkg::freq_t int_osc_r, ext_osc_r;
  ctfc_pkg::lim_t  lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_osc_r      <= ctfc_pkg::FreqW'(32'd16000000);
      ext_osc_r      <= ctfc_pkg::FreqW'(32'd25000000);
      lim_r.core     <= ctfc_pkg::FreqW'(32'd100000000);
      lim_r.apb_low  <= ctfc_pkg::FreqW'(32'd50000000);
      lim_r.apb_high <= ctfc_pkg::FreqW'(32'd100000000);
      lim_r.audio    <= ctfc_pkg::FreqW'(32'd192000000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ctfc_pkg::REG_INT_OSC:   int_osc_r      <= ctfc_pkg::FreqW'(cfg_data);
        ctfc_pkg::REG_EXT_OSC:   ext_osc_r      <= ctfc_pkg::FreqW'(cfg_data);
        ctfc_pkg::REG_MAX_CORE:  lim_r.core     <= cfg_data;
        ctfc_pkg::REG_MAX_APB_L: lim_r.apb_low  <= cfg_data;
        ctfc_pkg::REG_MAX_APB_H: lim_r.apb_high <= cfg_data;
        ctfc_pkg::REG_MAX_AUDIO: lim_r.audio    <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Capture stage: pick the PLL source, decode which PLL paths are live and
  // raise the zero-divisor flag up front.
  logic            s0_vld_r;
  ctfc_pkg::item_t s0_r, s0_nxt;
  logic            div1_ready;
  ctfc_pkg::freq_t pll_src;
  logic            main_sel, aud_live;

  assign pll_src  = in_pll_from_external ? ext_osc_r : int_osc_r;
  assign main_sel = (in_switch_status == 2'd2);
  assign aud_live = in_audio_ready && (in_audio_div_m != '0) && (in_audio_div_r != '0);

  always_comb begin
    s0_nxt               = '0;
    s0_nxt.main_val      = pll_src;
    s0_nxt.main_div      = in_main_div_m;
    s0_nxt.aud_val       = pll_src;
    s0_nxt.aud_div       = in_audio_div_m;
    s0_nxt.main_n        = in_main_mult_n;
    s0_nxt.aud_n         = in_audio_mult_n;
    s0_nxt.p_code        = in_main_p_code;
    s0_nxt.aud_r         = in_audio_div_r;
    s0_nxt.sys_src       = (in_switch_status == 2'd1) ? ext_osc_r : int_osc_r;
    s0_nxt.pll_sel       = main_sel;
    s0_nxt.main_live     = main_sel && (in_main_div_m != '0);
    s0_nxt.aud_live      = aud_live;
    s0_nxt.ahb_code      = in_ahb_code;
    s0_nxt.apb_low_code  = in_apb_low_code;
    s0_nxt.apb_high_code = in_apb_high_code;
    s0_nxt.err[0]        = (main_sel && (in_main_div_m == '0))
                         || (in_audio_ready && !aud_live);
  end

  assign in_ready = !s0_vld_r || div1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s0_r <= s0_nxt;
    end
  end

  // Source / M for both PLLs.
  logic            d1_vld, mul_ready;
  ctfc_pkg::item_t d1_item;

  ctfc_div u_div_m (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_vld_r),
    .in_ready  (div1_ready),
    .in_item   (s0_r),
    .out_valid (d1_vld),
    .out_ready (mul_ready),
    .out_item  (d1_item)
  );

  // Times N, with wrap detection.
  logic            m_vld, div2_ready;
  ctfc_pkg::item_t m_item;

  ctfc_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_vld),
    .in_ready  (mul_ready),
    .in_item   (d1_item),
    .out_valid (m_vld),
    .out_ready (div2_ready),
    .out_item  (m_item)
  );

  // VCO / P (main) and VCO / R (audio).
  logic            d2_vld, bus_ready;
  ctfc_pkg::item_t d2_item;

  ctfc_div u_div_pr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_vld),
    .in_ready  (div2_ready),
    .in_item   (m_item),
    .out_valid (d2_vld),
    .out_ready (bus_ready),
    .out_item  (d2_item)
  );

  // System clock select, prescalers, limits, output register.
  ctfc_bus u_bus (
    .clk             (clk),
    .rst_n           (rst_n),
    .lim             (lim_r),
    .in_valid        (d2_vld),
    .in_ready        (bus_ready),
    .in_item         (d2_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sysclk_hz   (out_sysclk_hz),
    .out_core_hz     (out_core_hz),
    .out_apb_low_hz  (out_apb_low_hz),
    .out_apb_high_hz (out_apb_high_hz),
    .out_audio_hz    (out_audio_hz),
    .out_over_limit  (out_over_limit),
    .out_math_error  (out_math_error)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for clock_tree_frequency_calc: random and directed
// clock-register snapshots checked against an in-bench frequency predictor.
// Depends on ctfc_pkg and the block RTL.
`default_nettype none

module tb_top;

  localparam int LATENCY   = 12;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 900;

  typedef struct packed {
    logic [1:0] sws;
    logic       pll_ext;
    logic [5:0] main_m;
    logic [8:0] main_n;
    logic [1:0] main_p;
    logic [3:0] ahb;
    logic [2:0] apb_lo;
    logic [2:0] apb_hi;
    logic [5:0] aud_m;
    logic [8:0] aud_n;
    logic [2:0] aud_r;
    logic       aud_rdy;
  } snap_t;

  typedef struct packed {
    logic [31:0] sys;
    logic [31:0] core;
    logic [31:0] apb_lo;
    logic [31:0] apb_hi;
    logic [31:0] audio;
    logic [3:0]  lim;
    logic [1:0]  err;
  } freqs_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  snap_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  freqs_t got;

  // Model copy of the register file.
  logic [31:0] osc_int, osc_ext, lim_core, lim_apb_lo, lim_apb_hi, lim_audio;

  snap_t  pending_reqs[$];
  freqs_t expected_freqs[$];
  int     n_fail = 0;
  int     n_checked = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_send = 1'b0;
  bit     timed_out = 1'b0;
  int     wdog = 0;

  clock_tree_frequency_calc dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .in_switch_status(in_req.sws),
    .in_pll_from_external(in_req.pll_ext),
    .in_main_div_m(in_req.main_m),
    .in_main_mult_n(in_req.main_n),
    .in_main_p_code(in_req.main_p),
    .in_ahb_code(in_req.ahb),
    .in_apb_low_code(in_req.apb_lo),
    .in_apb_high_code(in_req.apb_hi),
    .in_audio_div_m(in_req.aud_m),
    .in_audio_mult_n(in_req.aud_n),
    .in_audio_div_r(in_req.aud_r),
    .in_audio_ready(in_req.aud_rdy),
    .out_valid, .out_ready,
    .out_sysclk_hz(got.sys),
    .out_core_hz(got.core),
    .out_apb_low_hz(got.apb_lo),
    .out_apb_high_hz(got.apb_hi),
    .out_audio_hz(got.audio),
    .out_over_limit(got.lim),
    .out_math_error(got.err)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // PLL output ((src / m) * n) / d; zero m or d gives 0, wrap is flagged.
  function automatic logic [31:0] pll_freq(logic [31:0] src, logic [5:0] m,
                                           logic [8:0] n, logic [3:0] d,
                                           inout logic [1:0] err);
    logic [40:0] vco;
    if (m == 0 || d == 0) begin
      err[0] = 1'b1;
      return '0;
    end
    vco = 41'(src / m) * n;
    if (vco[40:32] != 0) err[1] = 1'b1;
    return vco[31:0] / d;
  endfunction

  function automatic int ahb_sh(logic [3:0] c);
    case (c)
      4'd8: return 1;
      4'd9: return 2;
      4'd10: return 3;
      4'd11: return 4;
      4'd12: return 6;
      4'd13: return 7;
      4'd14: return 8;
      4'd15: return 9;
      default: return 0;
    endcase
  endfunction

  function automatic int apb_sh(logic [2:0] c);
    return (c >= 3'd4) ? int'(c) - 3 : 0;
  endfunction

  function automatic freqs_t predict_freqs(snap_t s);
    freqs_t f;
    logic [31:0] src;
    f = '0;
    src = s.pll_ext ? osc_ext : osc_int;
    case (s.sws)
      2'd1: f.sys = osc_ext;
      2'd2: f.sys = pll_freq(src, s.main_m, s.main_n, 4'((s.main_p + 1) * 2), f.err);
      default: f.sys = osc_int;
    endcase
    f.core = f.sys >> ahb_sh(s.ahb);
    f.apb_lo = f.core >> apb_sh(s.apb_lo);
    f.apb_hi = f.core >> apb_sh(s.apb_hi);
    if (s.aud_rdy) f.audio = pll_freq(src, s.aud_m, s.aud_n, {1'b0, s.aud_r}, f.err);
    f.lim[0] = f.core > lim_core;
    f.lim[1] = f.apb_lo > lim_apb_lo;
    f.lim[2] = f.apb_hi > lim_apb_hi;
    f.lim[3] = f.audio > lim_audio;
    return f;
  endfunction

  // Driver: present the next request, hold it until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_freqs.push_back(predict_freqs(in_req));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_req   <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    freqs_t e;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (expected_freqs.size() == 0) begin
          $error("unexpected result sys=%0d", got.sys);
          n_fail++;
        end else begin
          e = expected_freqs.pop_front();
          n_checked++;
          if (got.sys !== e.sys) begin
            $error("sysclk_hz exp %0d got %0d", e.sys, got.sys); n_fail++;
          end
          if (got.core !== e.core) begin
            $error("core_hz exp %0d got %0d", e.core, got.core); n_fail++;
          end
          if (got.apb_lo !== e.apb_lo) begin
            $error("apb_low_hz exp %0d got %0d", e.apb_lo, got.apb_lo); n_fail++;
          end
          if (got.apb_hi !== e.apb_hi) begin
            $error("apb_high_hz exp %0d got %0d", e.apb_hi, got.apb_hi); n_fail++;
          end
          if (got.audio !== e.audio) begin
            $error("audio_hz exp %0d got %0d", e.audio, got.audio); n_fail++;
          end
          if (got.lim !== e.lim) begin
            $error("over_limit exp %0h got %0h", e.lim, got.lim); n_fail++;
          end
          if (got.err !== e.err) begin
            $error("math_error exp %0h got %0h", e.err, got.err); n_fail++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        (pending_reqs.size() == 0 && expected_freqs.size() == 0)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) timed_out = 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (timed_out) begin
        $display("[clock_tree_frequency_calc] ERROR");
        $finish;
      end
    end
  end

  function automatic snap_t rand_snap();
    snap_t s;
    logic [63:0] r;
    r = {$urandom, $urandom};
    s = r[$bits(snap_t)-1:0];
    // Bias toward sane PLL settings so flags do not dominate.
    if ($urandom_range(3) != 0) s.sws = 2'd2;
    if ($urandom_range(7) != 0 && s.main_m == 0) s.main_m = 6'd8;
    if ($urandom_range(7) != 0 && s.aud_m == 0) s.aud_m = 6'd8;
    if ($urandom_range(7) != 0 && s.aud_r == 0) s.aud_r = 3'd2;
    return s;
  endfunction

  // Wait for the block to drain, then write one register.
  task automatic write_reg(ctfc_pkg::cfg_reg_t idx, logic [31:0] val);
    while (pending_reqs.size() > 0 || in_valid || expected_freqs.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ctfc_pkg::REG_INT_OSC:   osc_int = val;
      ctfc_pkg::REG_EXT_OSC:   osc_ext = val;
      ctfc_pkg::REG_MAX_CORE:  lim_core = val;
      ctfc_pkg::REG_MAX_APB_L: lim_apb_lo = val;
      ctfc_pkg::REG_MAX_APB_H: lim_apb_hi = val;
      default:                 lim_audio = val;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_freqs.size() > 0) @(posedge clk);
  endtask

  initial begin
    snap_t s;
    osc_int = 32'd16000000;
    osc_ext = 32'd25000000;
    lim_core = 32'd100000000;
    lim_apb_lo = 32'd50000000;
    lim_apb_hi = 32'd100000000;
    lim_audio = 32'd192000000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every source, status three, zero dividers, wrap, not ready.
    for (int i = 0; i < 4; i++) begin
      s = '0;
      s.sws = 2'(i); s.pll_ext = i[0]; s.main_m = 6'd16; s.main_n = 9'd336;
      s.main_p = 2'(i); s.ahb = 4'(i * 5); s.apb_lo = 3'(i + 4); s.apb_hi = 3'(i);
      s.aud_m = 6'd16; s.aud_n = 9'd192; s.aud_r = 3'd2; s.aud_rdy = 1'b1;
      pending_reqs.push_back(s);
    end
    s = '1; pending_reqs.push_back(s);
    s.main_m = '0; s.aud_r = '0; pending_reqs.push_back(s);
    s = '1; s.main_m = 6'd1; s.aud_m = 6'd1; pending_reqs.push_back(s);
    s.aud_rdy = 1'b0; s.aud_m = '0; pending_reqs.push_back(s);
    s = '0; s.sws = 2'd2; pending_reqs.push_back(s);
    s.ahb = 4'd15; s.apb_lo = 3'd7; s.apb_hi = 3'd7; s.sws = 2'd1;
    pending_reqs.push_back(s);
    drain();

    // Extremes of the oscillators and limits, then random snapshots.
    write_reg(ctfc_pkg::REG_INT_OSC, 32'hFFFF_FFFF);
    write_reg(ctfc_pkg::REG_EXT_OSC, 32'd1);
    write_reg(ctfc_pkg::REG_MAX_CORE, 32'd0);
    write_reg(ctfc_pkg::REG_MAX_APB_L, 32'hFFFF_FFFF);
    write_reg(ctfc_pkg::REG_MAX_APB_H, 32'd0);
    write_reg(ctfc_pkg::REG_MAX_AUDIO, 32'hFFFF_FFFF);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < N_RANDOM / 6; i++) pending_reqs.push_back(rand_snap());
      if (ph == 3) begin
        // Hold the sender until every outstanding result is back.
        while (pending_reqs.size() > 100) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_freqs.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
      if (ph < 5) begin
        write_reg(ctfc_pkg::REG_INT_OSC,
                  (ph == 0) ? 32'd1 : $urandom_range(200000000, 1));
        write_reg(ctfc_pkg::REG_EXT_OSC,
                  (ph == 1) ? 32'hFFFF_FFFF : $urandom_range(200000000, 1));
        write_reg(ctfc_pkg::REG_MAX_CORE, $urandom);
        write_reg(ctfc_pkg::REG_MAX_APB_L,
                  (ph == 2) ? 32'd0 : $urandom_range(100000000));
        write_reg(ctfc_pkg::REG_MAX_APB_H, $urandom_range(100000000));
        write_reg(ctfc_pkg::REG_MAX_AUDIO,
                  (ph == 3) ? 32'd0 : $urandom_range(200000000));
      end
    end
    drain();
    repeat (LATENCY * 2) @(posedge clk);

    $display("Checked %0d results over 7 register settings and 4 flow-control mixes.",
             n_checked);
    if (n_fail == 0 && expected_freqs.size() == 0) begin
      $display("[clock_tree_frequency_calc] OK");
    end else begin
      $display("[clock_tree_frequency_calc] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
